/* rtl/ctg_pkg.sv */
package ctg_pkg;

  localparam int MAX_SEGMENTS    = 1024;
  localparam int SINE_TABLE_BITS = 10;
  localparam int COORD_FRAC_BITS = 16;

  localparam int SEG_W      = 10;
  localparam int STEP_W     = 15;
  localparam int ANG_W      = 16;
  localparam int COORD_W    = 32;
  localparam int LEN_W      = 31;
  localparam int AXIS_W     = 2;
  localparam int PART_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // sine table: unsigned Q1.30, quarter wave plus the endpoint
  localparam int SINE_FRAC = 30;
  localparam int ROM_DW    = SINE_FRAC + 1;
  localparam int ROM_AW    = SINE_TABLE_BITS + 1;
  localparam int ROM_SIZE  = (1 << SINE_TABLE_BITS) + 1;
  localparam int PROD_W    = ROM_DW + LEN_W;
  localparam int OFF_W     = PROD_W - SINE_FRAC;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [PART_W-1:0] PART_BOTTOM = 2'd0;
  localparam logic [PART_W-1:0] PART_TOP    = 2'd1;
  localparam logic [PART_W-1:0] PART_SIDE0  = 2'd2;
  localparam logic [PART_W-1:0] PART_SIDE1  = 2'd3;

  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(64'd1 << COORD_FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS       = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_CENTER_Z   = 3'd3,
    REG_HALF_LEN   = 3'd4,
    REG_RADIUS     = 3'd5,
    REG_ANGLE_STEP = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [AXIS_W-1:0]         axis;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [LEN_W-1:0]          half_length;
    logic [LEN_W-1:0]          radius;
  } cfg_t;

  typedef struct packed {
    logic [ANG_W-1:0] a0;
    logic [ANG_W-1:0] a1;
  } ang_pair_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef logic [ROM_DW-1:0] sine_rom_t [ROM_SIZE];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_ONE    = 64'd1 << SINE_FRAC;
  // (2i)(2i+1) for i = 1..7
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

  // integer Taylor series, truncating at each step, clamped to [0, 1.0]
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    int k;
    int i;
    for (k = 0; k < ROM_SIZE; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> SINE_FRAC;
      term = x;
      sum  = $signed(x);
      for (i = 1; i <= 7; i++) begin
        term = ((term * x2) >> SINE_FRAC) / TAYLOR_DIV[i-1];
        if ((i & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > $signed(SINE_ONE)) begin
        sum = $signed(SINE_ONE);
      end
      rom[k] = sum[ROM_DW-1:0];
    end
    return rom;
  endfunction

endpackage

/* rtl/ctg_front.sv */
module ctg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ctg_pkg::SEG_W-1:0]  segment_index,
  input  logic [ctg_pkg::STEP_W-1:0] angle_step,
  output logic                       push,
  output ctg_pkg::ang_pair_t         entry,
  input  logic                       full
);

  localparam int MUL_W = ctg_pkg::SEG_W + ctg_pkg::STEP_W;

  logic                        loaded;
  logic                        accept;
  logic                        in_range;
  logic [MUL_W-1:0]            prod;
  logic [ctg_pkg::ANG_W-1:0]   a0;

  assign push     = loaded && !full;
  assign in_ready = !loaded || push;
  assign accept   = in_valid && in_ready;
  assign in_range = 32'(segment_index) < 32'(ctg_pkg::MAX_SEGMENTS);

  // angles wrap modulo a full turn
  assign prod = MUL_W'(segment_index) * MUL_W'(angle_step);
  assign a0   = prod[ctg_pkg::ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (accept) begin
      loaded <= in_range;
    end else if (push) begin
      loaded <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry.a0 <= a0;
      entry.a1 <= a0 + ctg_pkg::ANG_W'(angle_step);
    end
  end

endmodule

/* rtl/ctg_queue.sv */
module ctg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctg_pkg::ang_pair_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output ctg_pkg::ang_pair_t head
);

  ctg_pkg::ang_pair_t                mem [ctg_pkg::QUEUE_DEPTH];
  logic [ctg_pkg::QPTR_W-1:0]        wr_ptr;
  logic [ctg_pkg::QPTR_W-1:0]        rd_ptr;
  logic [ctg_pkg::QCNT_W-1:0]        count;

  localparam logic [ctg_pkg::QPTR_W-1:0] PTR_LAST = ctg_pkg::QPTR_W'(ctg_pkg::QUEUE_DEPTH - 1);

  assign full  = count == ctg_pkg::QCNT_W'(ctg_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue pop while empty");

endmodule

/* rtl/ctg_back.sv */
module ctg_back (
  input  logic                       clk,
  input  logic                       rst,
  input  ctg_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  ctg_pkg::ang_pair_t         q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ctg_pkg::vec_t              v0,
  output ctg_pkg::vec_t              v1,
  output ctg_pkg::vec_t              v2,
  output logic [ctg_pkg::PART_W-1:0] part,
  output logic                       last
);

  localparam int W = ctg_pkg::COORD_W;

  typedef struct packed {
    logic [ctg_pkg::ROM_AW-1:0] addr;
    logic                       neg;
  } rom_rd_t;

  localparam ctg_pkg::sine_rom_t SINE_ROM_P0 = ctg_pkg::build_sine_rom();
  localparam ctg_pkg::sine_rom_t SINE_ROM_P1 = ctg_pkg::build_sine_rom();
  localparam logic [ctg_pkg::PROD_W-1:0] ROUND_HALF =
    ctg_pkg::PROD_W'(1) << (ctg_pkg::SINE_FRAC - 1);

  // quadrant folding onto the quarter-wave table
  function automatic rom_rd_t sine_lookup(logic [ctg_pkg::ANG_W-1:0] ang);
    rom_rd_t r;
    logic [ctg_pkg::SINE_TABLE_BITS-1:0] idx;
    idx    = ang[ctg_pkg::ANG_W-3 -: ctg_pkg::SINE_TABLE_BITS];
    r.addr = ang[ctg_pkg::ANG_W-2]
           ? ctg_pkg::ROM_AW'(1 << ctg_pkg::SINE_TABLE_BITS) - {1'b0, idx}
           : {1'b0, idx};
    r.neg  = ang[ctg_pkg::ANG_W-1];
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] base,
                                                  logic [ctg_pkg::OFF_W-1:0] mag,
                                                  logic neg);
    logic signed [W+1:0] b;
    logic signed [W+1:0] m;
    logic signed [W+1:0] r;
    logic signed [W-1:0] res;
    b = (W+2)'(base);
    m = $signed((W+2)'(mag));
    r = neg ? b - m : b + m;
    if (r > (W+2)'(64'sd2147483647)) begin
      res = {1'b0, {(W-1){1'b1}}};
    end else if (r < -(W+2)'(64'sd2147483648)) begin
      res = {1'b1, {(W-1){1'b0}}};
    end else begin
      res = r[W-1:0];
    end
    return res;
  endfunction

  function automatic ctg_pkg::vec_t place(logic [ctg_pkg::AXIS_W-1:0] ax,
                                          logic signed [W-1:0] end_val,
                                          logic signed [W-1:0] s_val,
                                          logic signed [W-1:0] c_val);
    ctg_pkg::vec_t v;
    unique case (ax)
      ctg_pkg::AXIS_X: begin
        v.x = end_val; v.y = s_val; v.z = c_val;
      end
      ctg_pkg::AXIS_Y: begin
        v.x = s_val; v.y = end_val; v.z = c_val;
      end
      default: begin
        v.x = c_val; v.y = s_val; v.z = end_val;
      end
    endcase
    return v;
  endfunction

  // slot order: sin a0, cos a0, sin a1, cos a1
  rom_rd_t lk [4];
  logic                              r_v;
  logic [ctg_pkg::ROM_DW-1:0]        r_rom0 [2];
  logic [ctg_pkg::ROM_DW-1:0]        r_rom1 [2];
  logic [ctg_pkg::ROM_DW-1:0]        r_data [4];
  logic [3:0]                        r_neg;
  logic                              m_v;
  logic [ctg_pkg::PROD_W-1:0]        m_prod [4];
  logic [3:0]                        m_neg;
  logic                              e_v;
  logic [ctg_pkg::OFF_W-1:0]         e_mag [4];
  logic [3:0]                        e_neg;
  logic [ctg_pkg::PART_W-1:0]        e_part;
  logic [ctg_pkg::PROD_W-1:0]        rounded [4];

  logic o_load, e_done, e_take, m_take, r_take;

  logic signed [W-1:0] axc, s_base, c_base, lo, hi;
  logic signed [W-1:0] p0s, p0c, p1s, p1c;
  ctg_pkg::vec_t c_lo, c_hi, p0_lo, p0_hi, p1_lo, p1_hi;
  ctg_pkg::vec_t t0, t1, t2;

  assign o_load = e_v && (!out_valid || out_ready);
  assign e_done = o_load && (e_part == ctg_pkg::PART_SIDE1);
  assign e_take = m_v && (!e_v || e_done);
  assign m_take = r_v && (!m_v || e_take);
  assign r_take = q_valid && (!r_v || m_take);
  assign q_pop  = r_take;

  assign lk[0] = sine_lookup(q_head.a0);
  assign lk[1] = sine_lookup(q_head.a0 + ctg_pkg::ANG_W'(16384));
  assign lk[2] = sine_lookup(q_head.a1);
  assign lk[3] = sine_lookup(q_head.a1 + ctg_pkg::ANG_W'(16384));

  // two ROM copies, two reads each
  always_ff @(posedge clk) begin
    if (r_take) begin
      r_rom0[0] <= SINE_ROM_P0[lk[0].addr];
      r_rom0[1] <= SINE_ROM_P0[lk[1].addr];
    end
  end

  always_ff @(posedge clk) begin
    if (r_take) begin
      r_rom1[0] <= SINE_ROM_P1[lk[2].addr];
      r_rom1[1] <= SINE_ROM_P1[lk[3].addr];
    end
  end

  always_ff @(posedge clk) begin
    if (r_take) begin
      r_neg <= {lk[3].neg, lk[2].neg, lk[1].neg, lk[0].neg};
    end
  end

  assign r_data[0] = r_rom0[0];
  assign r_data[1] = r_rom0[1];
  assign r_data[2] = r_rom1[0];
  assign r_data[3] = r_rom1[1];

  always_ff @(posedge clk) begin
    if (m_take) begin
      for (int k = 0; k < 4; k++) begin
        m_prod[k] <= ctg_pkg::PROD_W'(cfg.radius) * ctg_pkg::PROD_W'(r_data[k]);
      end
      m_neg <= r_neg;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rounded[k] = m_prod[k] + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (e_take) begin
      for (int k = 0; k < 4; k++) begin
        e_mag[k] <= rounded[k][ctg_pkg::PROD_W-1:ctg_pkg::SINE_FRAC];
      end
      e_neg <= m_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v       <= 1'b0;
      m_v       <= 1'b0;
      e_v       <= 1'b0;
      e_part    <= ctg_pkg::PART_BOTTOM;
      out_valid <= 1'b0;
    end else begin
      if (r_take) begin
        r_v <= 1'b1;
      end else if (m_take) begin
        r_v <= 1'b0;
      end
      if (m_take) begin
        m_v <= 1'b1;
      end else if (e_take) begin
        m_v <= 1'b0;
      end
      if (e_take) begin
        e_v <= 1'b1;
      end else if (e_done) begin
        e_v <= 1'b0;
      end
      if (e_take) begin
        e_part <= ctg_pkg::PART_BOTTOM;
      end else if (o_load) begin
        e_part <= e_part + 1'b1;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // rim coordinates off the axis do not depend on which end
  always_comb begin
    unique case (cfg.axis)
      ctg_pkg::AXIS_X: axc = cfg.center_x;
      ctg_pkg::AXIS_Y: axc = cfg.center_y;
      default:         axc = cfg.center_z;
    endcase
    s_base = (cfg.axis == ctg_pkg::AXIS_Y) ? cfg.center_x : cfg.center_y;
    c_base = (cfg.axis == ctg_pkg::AXIS_X || cfg.axis == ctg_pkg::AXIS_Y)
           ? cfg.center_z : cfg.center_x;
    lo  = sat_add(axc, ctg_pkg::OFF_W'(cfg.half_length), 1'b1);
    hi  = sat_add(axc, ctg_pkg::OFF_W'(cfg.half_length), 1'b0);
    p0s = sat_add(s_base, e_mag[0], e_neg[0]);
    p0c = sat_add(c_base, e_mag[1], e_neg[1]);
    p1s = sat_add(s_base, e_mag[2], e_neg[2]);
    p1c = sat_add(c_base, e_mag[3], e_neg[3]);
    c_lo  = place(cfg.axis, lo, s_base, c_base);
    c_hi  = place(cfg.axis, hi, s_base, c_base);
    p0_lo = place(cfg.axis, lo, p0s, p0c);
    p0_hi = place(cfg.axis, hi, p0s, p0c);
    p1_lo = place(cfg.axis, lo, p1s, p1c);
    p1_hi = place(cfg.axis, hi, p1s, p1c);
    unique case (e_part)
      ctg_pkg::PART_BOTTOM: begin
        t0 = c_lo; t1 = p0_lo; t2 = p1_lo;
      end
      ctg_pkg::PART_TOP: begin
        t0 = c_hi; t1 = p0_hi; t2 = p1_hi;
      end
      ctg_pkg::PART_SIDE0: begin
        t0 = p0_lo; t1 = p1_hi; t2 = p1_lo;
      end
      default: begin
        t0 = p0_lo; t1 = p1_hi; t2 = p0_hi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      v0   <= t0;
      v1   <= t1;
      v2   <= t2;
      part <= e_part;
      last <= e_part == ctg_pkg::PART_SIDE1;
    end
  end

  a_part_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && (part == $past(part) + 1'b1))
    else $error("triangle beats of a segment out of sequence");
  a_first_bottom: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> part == ctg_pkg::PART_BOTTOM)
    else $error("segment output does not start with the bottom cap");

endmodule

/* rtl/cylinder_triangle_generator_top.sv */
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// in       | in_valid / in_ready    | segment_index
// out      | out_valid / out_ready  | v0_x..v2_z, part, last (4 beats/segment)
// cfg      | cfg_write              | cfg_index, cfg_data (no wait, no read)
//
// Each segment gives four beats, one per cycle when the output is never
// stalled; the emitter sets this and takes the next segment on the last beat.
// A beat passes the front reg, then queue, sine ROM read, radius multiply,
// offset round and output reg, and either handshake can stall it on the way.
// Synchronous reset clears all valid state and loads the register defaults.
// A two-deep queue between front and back lets either side stall alone.
module cylinder_triangle_generator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ctg_pkg::SEG_W-1:0]         segment_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ctg_pkg::COORD_W-1:0] v0_x,
  output logic signed [ctg_pkg::COORD_W-1:0] v0_y,
  output logic signed [ctg_pkg::COORD_W-1:0] v0_z,
  output logic signed [ctg_pkg::COORD_W-1:0] v1_x,
  output logic signed [ctg_pkg::COORD_W-1:0] v1_y,
  output logic signed [ctg_pkg::COORD_W-1:0] v1_z,
  output logic signed [ctg_pkg::COORD_W-1:0] v2_x,
  output logic signed [ctg_pkg::COORD_W-1:0] v2_y,
  output logic signed [ctg_pkg::COORD_W-1:0] v2_z,
  output logic [ctg_pkg::PART_W-1:0]        part,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [ctg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ctg_pkg::cfg_t                cfg;
  logic [ctg_pkg::STEP_W-1:0]   angle_step;
  logic                         push;
  logic                         full;
  logic                         q_valid;
  logic                         q_pop;
  ctg_pkg::ang_pair_t           f_entry;
  ctg_pkg::ang_pair_t           q_head;
  ctg_pkg::vec_t                v0, v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis        <= ctg_pkg::AXIS_Z;
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.center_z    <= '0;
      cfg.half_length <= ctg_pkg::LEN_RESET;
      cfg.radius      <= ctg_pkg::LEN_RESET;
      angle_step      <= ctg_pkg::STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ctg_pkg::REG_AXIS:       cfg.axis        <= cfg_data[ctg_pkg::AXIS_W-1:0];
        ctg_pkg::REG_CENTER_X:   cfg.center_x    <= cfg_data;
        ctg_pkg::REG_CENTER_Y:   cfg.center_y    <= cfg_data;
        ctg_pkg::REG_CENTER_Z:   cfg.center_z    <= cfg_data;
        ctg_pkg::REG_HALF_LEN:   cfg.half_length <= cfg_data[ctg_pkg::LEN_W-1:0];
        ctg_pkg::REG_RADIUS:     cfg.radius      <= cfg_data[ctg_pkg::LEN_W-1:0];
        ctg_pkg::REG_ANGLE_STEP: angle_step      <= cfg_data[ctg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  ctg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .segment_index (segment_index),
    .angle_step    (angle_step),
    .push          (push),
    .entry         (f_entry),
    .full          (full)
  );

  ctg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (f_entry),
    .full       (full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  ctg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .v0        (v0),
    .v1        (v1),
    .v2        (v2),
    .part      (part),
    .last      (last)
  );

  assign v0_x = v0.x;
  assign v0_y = v0.y;
  assign v0_z = v0.z;
  assign v1_x = v1.x;
  assign v1_y = v1.y;
  assign v1_z = v1.z;
  assign v2_x = v2.x;
  assign v2_y = v2.y;
  assign v2_z = v2.z;

endmodule

/* tb/sv/cylinder_triangle_generator_top_test.sv */
`timescale 1ns / 1ps

module cylinder_triangle_generator_top_test;
  import ctg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAB_Q = 1 << SINE_TABLE_BITS;
  localparam longint unsigned QUARTER_PI2_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    vec_t              v0;
    vec_t              v1;
    vec_t              v2;
    logic [PART_W-1:0] part;
    logic              last;
  } tri_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SEG_W-1:0] segment_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  logic [PART_W-1:0] part;
  logic last;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cylinder_triangle_generator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .segment_index(segment_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .part(part), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the register file
  cfg_t geom = '{axis: AXIS_Z, center_x: '0, center_y: '0, center_z: '0,
                 half_length: LEN_RESET, radius: LEN_RESET};
  logic [STEP_W-1:0] seg_step = STEP_RESET;

  longint sine_tab [0:TAB_Q];
  logic [SEG_W-1:0] seg_pending [$];
  tri_beat_t tri_expected [$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int cycle_cnt = 0;

  function automatic void fill_sine_table();
    longint unsigned x, x2, term;
    longint sum;
    for (int k = 0; k <= TAB_Q; k++) begin
      x = (QUARTER_PI2_Q30 * longint'(k)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 7; i++) begin
        term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
        if (i % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      sine_tab[k] = sum;
    end
  endfunction

  function automatic longint sine_of(logic [ANG_W-1:0] a);
    logic [SINE_TABLE_BITS-1:0] idx;
    longint v;
    idx = a[13:14-SINE_TABLE_BITS];
    v = a[14] ? sine_tab[TAB_Q - int'(idx)] : sine_tab[idx];
    return a[15] ? -v : v;
  endfunction

  // radius * |sin|, rounded half up, sign put back after
  function automatic longint rim_offset(longint s);
    longint unsigned mag, off;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    off = ((longint'(geom.radius) * mag) + (ONE_Q30 >> 1)) >> 30;
    return (s < 0) ? -longint'(off) : longint'(off);
  endfunction

  function automatic logic signed [COORD_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic vec_t rim_vertex(longint cap_pos, bit on_rim, logic [ANG_W-1:0] ang);
    vec_t p;
    longint s, c;
    logic [ANG_W-1:0] ang_c;
    ang_c = ang + 16'd16384;
    s = on_rim ? rim_offset(sine_of(ang)) : 0;
    c = on_rim ? rim_offset(sine_of(ang_c)) : 0;
    if (geom.axis == AXIS_X) begin
      p.x = cap_pos[31:0];
      p.y = clip32(longint'(geom.center_y) + s);
      p.z = clip32(longint'(geom.center_z) + c);
    end else if (geom.axis == AXIS_Y) begin
      p.x = clip32(longint'(geom.center_x) + s);
      p.y = cap_pos[31:0];
      p.z = clip32(longint'(geom.center_z) + c);
    end else begin
      // axis code three falls in here as z
      p.x = clip32(longint'(geom.center_x) + c);
      p.y = clip32(longint'(geom.center_y) + s);
      p.z = cap_pos[31:0];
    end
    return p;
  endfunction

  task automatic predict_segment(logic [SEG_W-1:0] n);
    logic [31:0] prod0, prod1;
    logic [ANG_W-1:0] a0, a1;
    longint axc, lo, hi;
    tri_beat_t b;
    if (int'(n) >= MAX_SEGMENTS) return;
    prod0 = 32'(n) * 32'(seg_step);
    prod1 = (32'(n) + 32'd1) * 32'(seg_step);
    a0 = prod0[15:0];
    a1 = prod1[15:0];
    axc = (geom.axis == AXIS_X) ? longint'(geom.center_x) :
          (geom.axis == AXIS_Y) ? longint'(geom.center_y) : longint'(geom.center_z);
    lo = longint'(clip32(axc - longint'(geom.half_length)));
    hi = longint'(clip32(axc + longint'(geom.half_length)));
    b.v0 = rim_vertex(lo, 1'b0, '0);
    b.v1 = rim_vertex(lo, 1'b1, a0);
    b.v2 = rim_vertex(lo, 1'b1, a1);
    b.part = PART_BOTTOM; b.last = 1'b0;
    tri_expected.push_back(b);
    b.v0 = rim_vertex(hi, 1'b0, '0);
    b.v1 = rim_vertex(hi, 1'b1, a0);
    b.v2 = rim_vertex(hi, 1'b1, a1);
    b.part = PART_TOP;
    tri_expected.push_back(b);
    b.v0 = rim_vertex(lo, 1'b1, a0);
    b.v1 = rim_vertex(hi, 1'b1, a1);
    b.v2 = rim_vertex(lo, 1'b1, a1);
    b.part = PART_SIDE0;
    tri_expected.push_back(b);
    b.v2 = rim_vertex(hi, 1'b1, a0);
    b.part = PART_SIDE1; b.last = 1'b1;
    tri_expected.push_back(b);
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk) begin : drive
    logic nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        predict_segment(segment_index);
        send_gap = quiet ? 0 : $urandom_range(0, 7);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (seg_pending.size() > 0) begin
          segment_index <= seg_pending.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // receiver and checker
  int recv_wait = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin : watch
    tri_beat_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (tri_expected.size() == 0) begin
          $error("unexpected triangle beat, part %0d", part);
          errors++;
        end else begin
          want = tri_expected.pop_front();
          check_field("v0_x", want.v0.x, v0_x);
          check_field("v0_y", want.v0.y, v0_y);
          check_field("v0_z", want.v0.z, v0_z);
          check_field("v1_x", want.v1.x, v1_x);
          check_field("v1_y", want.v1.y, v1_y);
          check_field("v1_z", want.v1.z, v1_z);
          check_field("v2_x", want.v2.x, v2_x);
          check_field("v2_y", want.v2.y, v2_y);
          check_field("v2_z", want.v2.z, v2_z);
          check_field("part", want.part, part);
          check_field("last", want.last, last);
        end
        recv_wait = quiet ? 0 : $urandom_range(0, 7);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    case (r)
      REG_AXIS:       geom.axis = d[AXIS_W-1:0];
      REG_CENTER_X:   geom.center_x = d;
      REG_CENTER_Y:   geom.center_y = d;
      REG_CENTER_Z:   geom.center_z = d;
      REG_HALF_LEN:   geom.half_length = d[LEN_W-1:0];
      REG_RADIUS:     geom.radius = d[LEN_W-1:0];
      REG_ANGLE_STEP: seg_step = d[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait until every offered segment has come back, then let the pipe settle
  task automatic drain();
    while (seg_pending.size() > 0 || in_valid || tri_expected.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
  endfunction

  function automatic logic [31:0] pick_len();
    if ($urandom_range(0, 3) == 0) return $urandom() & 32'h7FFF_FFFF;
    return $urandom_range(0, 32'hFF_FFFF);
  endfunction

  initial begin
    int ring_n;
    int k;
    int base;
    fill_sine_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, index extremes and alternating bits
    seg_pending = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1023, 10'h155, 10'h2AA};
    drain();

    // x axis, saturating centers and lengths, widest step
    write_reg(REG_AXIS, AXIS_X);
    write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h8000_0000);
    write_reg(REG_CENTER_Z, 32'h7FFF_0000);
    write_reg(REG_HALF_LEN, 32'h7FFF_FFFF);
    write_reg(REG_RADIUS, 32'h7FFF_FFFF);
    write_reg(REG_ANGLE_STEP, 32'd21845);
    end_writes();
    seg_pending = '{10'd0, 10'd1023, 10'd3, 10'd300};
    drain();

    // y axis, zero sizes, step of one
    write_reg(REG_AXIS, AXIS_Y);
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Z, 32'h8000_0000);
    write_reg(REG_HALF_LEN, 32'd0);
    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_ANGLE_STEP, 32'd1);
    end_writes();
    seg_pending = '{10'd0, 10'd1023, 10'd5};
    drain();

    // axis code three, zero step gives degenerate triangles
    write_reg(REG_AXIS, 32'd3);
    write_reg(REG_CENTER_X, 32'h0001_8000);
    write_reg(REG_CENTER_Y, 32'hFFFE_0000);
    write_reg(REG_CENTER_Z, 32'h0000_4000);
    write_reg(REG_HALF_LEN, 32'h0002_0000);
    write_reg(REG_RADIUS, 32'h0003_0000);
    write_reg(REG_ANGLE_STEP, 32'd0);
    end_writes();
    seg_pending = '{10'd7, 10'd1023};
    drain();

    write_reg(REG_AXIS, AXIS_Z);
    write_reg(REG_ANGLE_STEP, 32'd10922);
    end_writes();
    seg_pending = '{10'd0, 10'd1, 10'd2, 10'd6};
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_AXIS, $urandom_range(0, 3));
      write_reg(REG_CENTER_X, pick_coord());
      write_reg(REG_CENTER_Y, pick_coord());
      write_reg(REG_CENTER_Z, pick_coord());
      write_reg(REG_HALF_LEN, pick_len());
      write_reg(REG_RADIUS, pick_len());
      ring_n = $urandom_range(3, 20);
      if ($urandom_range(0, 3) == 0) write_reg(REG_ANGLE_STEP, $urandom_range(1, 21845));
      else write_reg(REG_ANGLE_STEP, 32'(65536 / ring_n));
      end_writes();
      quiet = (phase == 2);
      // ring_n consecutive segments from a random start (a full ring unless the step was random), then stray segments
      base = $urandom_range(0, 1023);
      for (k = 0; k < ring_n; k++) seg_pending.push_back(SEG_W'(base + k));
      for (; k < 24; k++) seg_pending.push_back(SEG_W'($urandom_range(0, 1023)));
      if (phase == 4) hold_req++;
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
